/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned ModeBits   = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned HeldBits   = 4;

  typedef enum logic [ModeBits-1:0] {
    MODE_INSERT     = 2'd0,
    MODE_REMOVE_MAX = 2'd1,
    MODE_REMOVE_MIN = 2'd2,
    MODE_UNUSED     = 2'd3
  } spq_mode_e;

  typedef enum logic [StatusBits-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic ins;
    logic pop_head;
  } spq_cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 8
) (
  input  wire                        clk_i,
  input  wire spq_pkg::spq_cell_ctrl_t ctrl_i,
  input  wire logic signed [KEY_BITS-1:0] new_key_i,
  input  wire logic [TAG_BITS-1:0]   new_tag_i,
  input  wire logic                  occ_i,
  input  wire logic                  left_take_i,
  input  wire logic signed [KEY_BITS-1:0] left_key_i,
  input  wire logic [TAG_BITS-1:0]   left_tag_i,
  input  wire logic signed [KEY_BITS-1:0] right_key_i,
  input  wire logic [TAG_BITS-1:0]   right_tag_i,
  output logic                       take_o,
  output logic signed [KEY_BITS-1:0] key_o,
  output logic [TAG_BITS-1:0]        tag_o
);

  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0]        tag_q, tag_d;

  // The new entry belongs at or ahead of this slot when the slot is free or holds a smaller key.
  assign take_o = !occ_i || (key_q < new_key_i);

  always_comb begin
    key_d = key_q;
    tag_d = tag_q;
    if (ctrl_i.ins && take_o) begin
      if (left_take_i) begin
        key_d = left_key_i;
        tag_d = left_tag_i;
      end else begin
        key_d = new_key_i;
        tag_d = new_tag_i;
      end
    end else if (ctrl_i.pop_head) begin
      key_d = right_key_i;
      tag_d = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    tag_q <= tag_d;
  end

  assign key_o = key_q;
  assign tag_o = tag_q;

endmodule

`default_nettype wire

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue built from a row of compare-and-shift cells.
// Input channel: in_valid_i, in_stall_o, mode_i, key_i, tag_i. A request is
// taken at a rising edge with in_valid_i high and in_stall_o low. Mode insert
// places the entry behind every stored entry with an equal or larger key;
// remove-max returns the head entry and remove-min the tail entry.
// Output channel: out_valid_o, out_stall_i, status_o, out_key_o, out_tag_o,
// entries_held_o. Every request yields exactly one result, registered and
// shown in the cycle after the request is taken.
// Throughput is one request per cycle while in_stall_o is low: each cell
// compares its own key with the incoming key and either holds, loads the new
// entry, or loads from a neighbour in the same cycle, so the whole row updates at once.
// While a result waits under out_stall_i the single result register is
// occupied and in_stall_o is raised until the result is taken.
// Reset clears the fill count and the result valid flag, leaving the queue
// empty; cell contents are not cleared and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 8,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned TAG_BITS = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [spq_pkg::ModeBits-1:0] mode_i,
  input  wire logic signed [KEY_BITS-1:0] key_i,
  input  wire logic [TAG_BITS-1:0]        tag_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [spq_pkg::StatusBits-1:0]  status_o,
  output logic signed [KEY_BITS-1:0]      out_key_o,
  output logic [TAG_BITS-1:0]             out_tag_o,
  output logic [spq_pkg::HeldBits-1:0]    entries_held_o
);

  localparam int unsigned CountBits = $clog2(CAPACITY + 1);

  logic                  accept;
  spq_pkg::spq_mode_e    mode;
  logic [CountBits-1:0]  count_q, count_d;
  logic                  is_full, is_empty;
  spq_pkg::spq_cell_ctrl_t ctrl;

  logic [CAPACITY-1:0]   occ, take, tail;
  logic signed [KEY_BITS-1:0] cell_key [CAPACITY];
  logic [TAG_BITS-1:0]        cell_tag [CAPACITY];
  logic signed [KEY_BITS-1:0] tail_key;
  logic [TAG_BITS-1:0]        tail_tag;

  logic                  out_valid_q;
  spq_pkg::spq_status_e  status_q, status_d;
  logic signed [KEY_BITS-1:0] out_key_q, out_key_d;
  logic [TAG_BITS-1:0]   out_tag_q, out_tag_d;
  logic [CountBits+spq_pkg::HeldBits-1:0] count_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign mode       = spq_pkg::spq_mode_e'(mode_i);
  assign is_full    = (count_q >= CountBits'(CAPACITY));
  assign is_empty   = (count_q == '0);

  assign ctrl.ins      = accept && (mode == spq_pkg::MODE_INSERT) && !is_full;
  assign ctrl.pop_head = accept && (mode == spq_pkg::MODE_REMOVE_MAX) && !is_empty;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (count_q > CountBits'(i));
    if (i == CAPACITY - 1) begin : g_last
      assign tail[i] = occ[i];
    end else begin : g_mid
      assign tail[i] = occ[i] && !occ[i+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_key_i   (key_i),
      .new_tag_i   (tag_i),
      .occ_i       (occ[i]),
      .left_take_i ((i == 0) ? 1'b0 : take[(i == 0) ? 0 : i-1]),
      .left_key_i  (cell_key[(i == 0) ? 0 : i-1]),
      .left_tag_i  (cell_tag[(i == 0) ? 0 : i-1]),
      .right_key_i ((i == CAPACITY - 1) ? '0 : cell_key[(i == CAPACITY - 1) ? i : i+1]),
      .right_tag_i ((i == CAPACITY - 1) ? '0 : cell_tag[(i == CAPACITY - 1) ? i : i+1]),
      .take_o      (take[i]),
      .key_o       (cell_key[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_comb begin
    tail_key = '0;
    tail_tag = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      tail_key = tail_key | (tail[i] ? cell_key[i] : '0);
      tail_tag = tail_tag | (tail[i] ? cell_tag[i] : '0);
    end
  end

  always_comb begin
    count_d   = count_q;
    status_d  = spq_pkg::STATUS_OK;
    out_key_d = '0;
    out_tag_d = '0;
    unique case (mode)
      spq_pkg::MODE_INSERT: begin
        if (is_full) begin
          status_d = spq_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CountBits'(1);
        end
      end
      spq_pkg::MODE_REMOVE_MAX: begin
        if (is_empty) begin
          status_d = spq_pkg::STATUS_EMPTY;
        end else begin
          count_d   = count_q - CountBits'(1);
          out_key_d = cell_key[0];
          out_tag_d = cell_tag[0];
        end
      end
      spq_pkg::MODE_REMOVE_MIN: begin
        if (is_empty) begin
          status_d = spq_pkg::STATUS_EMPTY;
        end else begin
          count_d   = count_q - CountBits'(1);
          out_key_d = tail_key;
          out_tag_d = tail_tag;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      out_key_q <= out_key_d;
      out_tag_q <= out_tag_d;
    end
  end

  assign count_ext      = {{spq_pkg::HeldBits{1'b0}}, count_q};
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_key_o      = out_key_q;
  assign out_tag_o      = out_tag_q;
  assign entries_held_o = count_ext[spq_pkg::HeldBits-1:0];

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountBits'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_full_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == spq_pkg::MODE_INSERT) && is_full |=>
      (status_o == spq_pkg::STATUS_FULL) && $stable(count_q))
    else $error("insert into full queue was not dropped");

  a_remove_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ((mode == spq_pkg::MODE_REMOVE_MAX) || (mode == spq_pkg::MODE_REMOVE_MIN))
      && !is_empty |=> count_q == $past(count_q) - CountBits'(1))
    else $error("removal did not reduce the fill count");

  a_held_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_held_o == count_ext[spq_pkg::HeldBits-1:0])
    else $error("reported entry count differs from the fill count");

endmodule

`default_nettype wire
